### sv/lsts_pkg.sv
// ============================================================================
// lsts_pkg: shared types and constants of the line-scan track steering block
// Item structs, configuration set, edge-search state and steering limits.
// ============================================================================
package lsts_pkg;

   // One camera sample as it arrives on the request channel.
   typedef struct packed {
      logic [15:0] pixel;
      logic        line_start;
      logic        line_end;
   } req_type;

   // One steering result, given on the last pixel of a line.
   typedef struct packed {
      logic [6:0] mid_index;
      logic       left_found;
      logic       right_found;
      logic [6:0] servo_tenths;
      logic [1:0] turn_class;
      logic [6:0] left_wheel_duty;
      logic [6:0] right_wheel_duty;
   } rsp_type;

   // Register indexes on the configuration port.
   typedef enum logic [2:0] {
      CSR_EDGE_STEP      = 3'd0,
      CSR_MIN_RUN        = 3'd1,
      CSR_MIN_EDGE_GAP   = 3'd2,
      CSR_STRAIGHT_SPEED = 3'd3,
      CSR_OUTSIDE_SPEED  = 3'd4,
      CSR_INSIDE_SPEED   = 3'd5,
      CSR_RIGHT_TRIM     = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      TURN_STRAIGHT = 2'd0,
      TURN_RIGHT    = 2'd1,
      TURN_LEFT     = 2'd2
   } turn_class_type;

   typedef struct packed {
      logic [15:0] edge_step;
      logic [6:0]  min_run;
      logic [6:0]  min_edge_gap;
      logic [6:0]  straight_speed;
      logic [6:0]  outside_speed;
      logic [6:0]  inside_speed;
      logic [6:0]  right_trim;
   } cfg_type;

   // Edge results of the current line as seen after the present pixel.
   typedef struct packed {
      logic [6:0] left_edge;
      logic [6:0] right_edge;
      logic       have_left;
      logic       have_right;
   } edges_type;

   localparam logic [15:0] EDGE_STEP_RESET      = 16'd13000;
   localparam logic [6:0]  MIN_RUN_RESET        = 7'd1;
   localparam logic [6:0]  MIN_EDGE_GAP_RESET   = 7'd17;
   localparam logic [6:0]  STRAIGHT_SPEED_RESET = 7'd40;
   localparam logic [6:0]  OUTSIDE_SPEED_RESET  = 7'd30;
   localparam logic [6:0]  INSIDE_SPEED_RESET   = 7'd20;
   localparam logic [6:0]  RIGHT_TRIM_RESET     = 7'd2;

   localparam logic [6:0] COUNT_MAX         = 7'd127;
   localparam logic [6:0] CENTER_LOW        = 7'd50;
   localparam logic [6:0] CENTER_HIGH       = 7'd90;
   localparam logic [7:0] SERVO_OFFSET      = 8'd170;
   localparam logic [6:0] SERVO_MAX         = 7'd120;
   localparam logic [6:0] SERVO_MIN         = 7'd80;
   localparam logic [6:0] SHARP_RIGHT_ABOVE = 7'd115;
   localparam logic [6:0] SHARP_LEFT_BELOW  = 7'd93;

endpackage

### sv/line_scan_track_steering.sv
// ============================================================================
// line_scan_track_steering: line-scan camera track follower
// Finds the two track edges in each camera line and steers toward the center.
// ============================================================================
//
//   Channel  Direction  Handshake            Payload
//   req_     in         req_valid/req_stall  lsts_pkg::req_type, one pixel
//   rsp_     out        rsp_valid/rsp_stall  lsts_pkg::rsp_type, one per line
//   csr_     in         csr_write            csr_index, csr_wdata
//
// Each pixel item is held in the input register and, when it ends a line,
// its result is held in the result register; throughput is one item per clock,
// except while a line-end pixel waits on a stalled result register.
// A synchronous reset clears edge state and valid flags, sets config defaults.
// While a result is held by rsp_stall, pixels that end no line still pass;
// a line-end pixel waits in the input register until the result is taken.

module line_scan_track_steering #(
   parameter int TOP_INDEX = 125
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lsts_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lsts_pkg::rsp_type rsp_data,
   input  logic              csr_write,
   input  logic [2:0]        csr_index,
   input  logic [15:0]       csr_wdata
);

   lsts_pkg::cfg_type   cfg_ff;
   lsts_pkg::req_type   item_ff;
   logic                item_valid_ff;
   logic                advance;
   lsts_pkg::edges_type edges_next;
   lsts_pkg::rsp_type   result;
   lsts_pkg::rsp_type   rsp_data_ff;
   logic                rsp_valid_ff;

   // Configuration registers; edge step keeps all 16 bits, the rest the low 7.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.edge_step      <= lsts_pkg::EDGE_STEP_RESET;
         cfg_ff.min_run        <= lsts_pkg::MIN_RUN_RESET;
         cfg_ff.min_edge_gap   <= lsts_pkg::MIN_EDGE_GAP_RESET;
         cfg_ff.straight_speed <= lsts_pkg::STRAIGHT_SPEED_RESET;
         cfg_ff.outside_speed  <= lsts_pkg::OUTSIDE_SPEED_RESET;
         cfg_ff.inside_speed   <= lsts_pkg::INSIDE_SPEED_RESET;
         cfg_ff.right_trim     <= lsts_pkg::RIGHT_TRIM_RESET;
      end else if (csr_write) begin
         case (csr_index)
            lsts_pkg::CSR_EDGE_STEP:      cfg_ff.edge_step      <= csr_wdata;
            lsts_pkg::CSR_MIN_RUN:        cfg_ff.min_run        <= csr_wdata[6:0];
            lsts_pkg::CSR_MIN_EDGE_GAP:   cfg_ff.min_edge_gap   <= csr_wdata[6:0];
            lsts_pkg::CSR_STRAIGHT_SPEED: cfg_ff.straight_speed <= csr_wdata[6:0];
            lsts_pkg::CSR_OUTSIDE_SPEED:  cfg_ff.outside_speed  <= csr_wdata[6:0];
            lsts_pkg::CSR_INSIDE_SPEED:   cfg_ff.inside_speed   <= csr_wdata[6:0];
            lsts_pkg::CSR_RIGHT_TRIM:     cfg_ff.right_trim     <= csr_wdata[6:0];
            default: begin
            end
         endcase
      end
   end

   // The held item moves on unless it ends a line and the result register
   // is occupied by a result that the consumer is still stalling.
   assign advance   = item_valid_ff &&
                      (!item_ff.line_end || !rsp_valid_ff || !rsp_stall);
   assign req_stall = item_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         item_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         item_ff <= req_data;
      end
   end

   lsts_track #(
      .TOP_INDEX (TOP_INDEX)
   ) u_track (
      .clock      (clock),
      .reset      (reset),
      .fire       (advance),
      .item       (item_ff),
      .cfg        (cfg_ff),
      .edges_next (edges_next)
   );

   // The result uses the edges as they stand after the line's last pixel.
   lsts_steer u_steer (
      .edges  (edges_next),
      .cfg    (cfg_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && item_ff.line_end) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && item_ff.line_end) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### sv/lsts_track.sv
// ============================================================================
// lsts_track: edge search over one camera line
// Holds the previous pixel, run and gap counters, pixel index and edges.
// ============================================================================
module lsts_track #(
   parameter int TOP_INDEX = 125
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               fire,
   input  lsts_pkg::req_type  item,
   input  lsts_pkg::cfg_type  cfg,
   output lsts_pkg::edges_type edges_next
);

   logic [15:0] prev_pixel_ff, prev_pixel_in;
   logic [6:0]  run_count_ff, run_count_in;
   logic [6:0]  gap_count_ff, gap_count_in;
   logic [6:0]  pixel_index_ff, pixel_index_in;
   lsts_pkg::edges_type edges_ff, edges_in;
   logic [15:0] diff;
   logic        run_ok;

   always_comb begin
      prev_pixel_in  = item.pixel;
      run_count_in   = run_count_ff;
      gap_count_in   = gap_count_ff;
      pixel_index_in = pixel_index_ff;
      edges_in       = edges_ff;
      diff = (item.pixel >= prev_pixel_ff) ? (item.pixel - prev_pixel_ff)
                                           : (prev_pixel_ff - item.pixel);
      run_ok = 1'b0;
      if (item.line_start) begin
         pixel_index_in      = 7'(TOP_INDEX);
         run_count_in        = '0;
         gap_count_in        = '0;
         edges_in.have_left  = 1'b0;
         edges_in.have_right = 1'b0;
      end else begin
         if (diff >= cfg.edge_step) begin
            if (run_count_ff != lsts_pkg::COUNT_MAX) begin
               run_count_in = run_count_ff + 7'd1;
            end
         end else begin
            run_count_in = '0;
         end
         run_ok = (run_count_in >= cfg.min_run);
         if (!edges_ff.have_left) begin
            if (run_ok) begin
               edges_in.left_edge = pixel_index_ff;
               edges_in.have_left = 1'b1;
            end
         end else if (!edges_ff.have_right && gap_count_ff > cfg.min_edge_gap) begin
            if (run_ok) begin
               edges_in.right_edge = pixel_index_ff;
               edges_in.have_right = 1'b1;
            end
         end else if (!edges_ff.have_right) begin
            if (gap_count_ff != lsts_pkg::COUNT_MAX) begin
               gap_count_in = gap_count_ff + 7'd1;
            end
         end
         if (pixel_index_ff != 7'd0) begin
            pixel_index_in = pixel_index_ff - 7'd1;
         end
      end
   end

   assign edges_next = edges_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_pixel_ff  <= '0;
         run_count_ff   <= '0;
         gap_count_ff   <= '0;
         pixel_index_ff <= '0;
         edges_ff       <= '0;
      end else if (fire) begin
         prev_pixel_ff  <= prev_pixel_in;
         run_count_ff   <= run_count_in;
         gap_count_ff   <= gap_count_in;
         pixel_index_ff <= pixel_index_in;
         edges_ff       <= edges_in;
      end
   end

endmodule

### sv/lsts_steer.sv
// ============================================================================
// lsts_steer: steering result from the edges of a line
// Center, clamped servo duty, turn class and wheel duties, right one trimmed.
// ============================================================================
module lsts_steer (
   input  lsts_pkg::edges_type edges,
   input  lsts_pkg::cfg_type   cfg,
   output lsts_pkg::rsp_type   result
);

   logic signed [7:0] d;
   logic [7:0]        mag;
   logic [7:0]        half_mag;
   logic [7:0]        sum;
   logic [6:0]        center;
   logic [6:0]        servo;
   logic [6:0]        lw;
   logic [6:0]        rw_base;
   lsts_pkg::turn_class_type cls;

   always_comb begin
      // The halving truncates toward zero, so it works on the magnitude.
      d        = $signed({1'b0, edges.left_edge}) - $signed({1'b0, edges.right_edge});
      mag      = d[7] ? 8'(-d) : 8'(d);
      half_mag = mag >> 1;
      sum      = d[7] ? ({1'b0, edges.right_edge} - half_mag)
                      : ({1'b0, edges.right_edge} + half_mag);
      center   = sum[6:0];

      if (center < lsts_pkg::CENTER_LOW) begin
         servo = lsts_pkg::SERVO_MAX;
      end else if (center <= lsts_pkg::CENTER_HIGH) begin
         servo = 7'(lsts_pkg::SERVO_OFFSET - {1'b0, center});
      end else begin
         servo = lsts_pkg::SERVO_MIN;
      end

      if (servo > lsts_pkg::SHARP_RIGHT_ABOVE) begin
         cls = lsts_pkg::TURN_RIGHT;  lw = cfg.outside_speed; rw_base = cfg.inside_speed;
      end else if (servo < lsts_pkg::SHARP_LEFT_BELOW) begin
         cls = lsts_pkg::TURN_LEFT;   lw = cfg.inside_speed;  rw_base = cfg.outside_speed;
      end else begin
         cls = lsts_pkg::TURN_STRAIGHT; lw = cfg.straight_speed; rw_base = cfg.straight_speed;
      end

      result.mid_index        = center;
      result.left_found       = edges.have_left;
      result.right_found      = edges.have_right;
      result.servo_tenths     = servo;
      result.turn_class       = cls;
      result.left_wheel_duty  = lw;
      result.right_wheel_duty = (rw_base > cfg.right_trim) ? (rw_base - cfg.right_trim) : 7'd0;
   end

endmodule

### sv/lsts_checker.sv
// ============================================================================
// lsts_port_props: port-level checks of the track steering block
// Stalled result hold, reset clear, servo range, turn class, edge flag order.
// ============================================================================
module lsts_port_props (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input lsts_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or vanished");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_servo_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.servo_tenths >= lsts_pkg::SERVO_MIN &&
                    rsp_data.servo_tenths <= lsts_pkg::SERVO_MAX)
      else $error("servo duty outside its clamp");

   a_class_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_data.turn_class == lsts_pkg::TURN_RIGHT &&
          rsp_data.servo_tenths > lsts_pkg::SHARP_RIGHT_ABOVE) ||
         (rsp_data.turn_class == lsts_pkg::TURN_LEFT &&
          rsp_data.servo_tenths < lsts_pkg::SHARP_LEFT_BELOW) ||
         (rsp_data.turn_class == lsts_pkg::TURN_STRAIGHT &&
          rsp_data.servo_tenths <= lsts_pkg::SHARP_RIGHT_ABOVE &&
          rsp_data.servo_tenths >= lsts_pkg::SHARP_LEFT_BELOW))
      else $error("turn class does not match servo duty");

   a_right_after_left: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.right_found |-> rsp_data.left_found)
      else $error("right edge reported without a left edge");

endmodule

bind line_scan_track_steering lsts_port_props u_lsts_port_props (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
